// ----- rtl/core/uer_pkg.sv -----
// Shared types and constants of the ultrasonic echo ranger.
// Used by every module under rtl/core; depends on nothing else.

package uer_pkg;

	// Field widths of the item and result channels.
	localparam int STAMP_IN_W = 16;
	localparam int TPS_W      = 24;
	localparam int PERIOD_W   = 10;
	localparam int SPEED_W    = 8;
	localparam int PULSE_W    = 16;
	localparam int WHOLE_W    = 14;
	localparam int THOU_W     = 10;
	localparam int US_W       = 20;
	localparam int PROD_W     = SPEED_W + PULSE_W;
	localparam int CFG_IDX_W  = 2;

	// Default build choices.
	localparam int STAMP_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Arithmetic constants.
	localparam logic [US_W-1:0]    US_PER_S    = 20'd1000000;
	localparam logic [PULSE_W-1:0] PULSE_MAX   = 16'hFFFF;
	localparam logic [PROD_W:0]    HALF_MM_DIV = 25'd2000;

	// Command codes.
	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_CAPTURE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_PERIOD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR     = 2'd2;

	// Register reset values.
	localparam logic [TPS_W-1:0]    TPS_RESET    = 24'd62500;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd700;
	localparam logic [SPEED_W-1:0]  SPEED_RESET  = 8'd33;

	// One input item.
	typedef struct packed {
		logic                  command;
		logic [STAMP_IN_W-1:0] capture_time;
	} event_t;

	// One result item.
	typedef struct packed {
		logic               trigger_out;
		logic               expect_rising;
		logic               result_valid;
		logic [PULSE_W-1:0] pulse_us;
		logic [WHOLE_W-1:0] distance_whole;
		logic [THOU_W-1:0]  distance_thousandths;
	} result_t;

	// Classification of an item, passed from front to back.
	typedef struct packed {
		logic trigger_out;
		logic expect_rising;
		logic measure;
	} entry_flags_t;

	// Fill status of the item queue.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ----- rtl/core/ultrasonic_echo_ranger.sv -----
// Top level of the ultrasonic echo ranger: configuration registers, front,
// item queue and back part. Depends on uer_pkg, uer_front, uer_queue, uer_back.
//
// Usage:
//   Input channel (event_valid / event_stall / event_item) takes trigger ticks
//   and echo edge captures. Output channel (meas_valid / meas_stall /
//   meas_item) gives exactly one result item per input item, in order.
//   The configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_wdata)
//   writes ticks_per_second, trigger_period and speed_factor; cfg_ready is
//   always high and unknown indexes are dropped.
// Sequencing:
//   After a tick or rising-edge item leaves the queue, the back part runs
//   B_MUL2, B_DIV2 and B_REM and raises meas_valid in B_OUT. A falling-edge
//   item first runs B_MUL1, B_SAT and the 16-step pulse divider; the divider
//   is skipped when the pulse width saturates.
//   The back part handles one item at a time and pops no new one before B_OUT.
//   The front accepts items until the item queue (QUEUE_DEPTH entries) fills.
// Reset: control state clears, registers return to their defaults, no result
//   is pending. A stalled receiver holds the result register; the queue then
//   fills and event_stall rises.

module ultrasonic_echo_ranger #(
	parameter int STAMP_BITS  = uer_pkg::STAMP_BITS_DEF,
	parameter int QUEUE_DEPTH = uer_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             event_valid,
	output logic                             event_stall,
	input  uer_pkg::event_t                  event_item,
	output logic                             meas_valid,
	input  logic                             meas_stall,
	output uer_pkg::result_t                 meas_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [uer_pkg::TPS_W-1:0]        cfg_wdata
);

	localparam int FLAGS_W = $bits(uer_pkg::entry_flags_t);
	localparam int ENTRY_W = FLAGS_W + STAMP_BITS;

	logic [uer_pkg::TPS_W-1:0]    tps_q;
	logic [uer_pkg::PERIOD_W-1:0] period_q;
	logic [uer_pkg::SPEED_W-1:0]  speed_q;

	logic                         accept;
	logic                         pop;
	uer_pkg::queue_status_t       q_status;
	uer_pkg::entry_flags_t        push_flags, pop_flags;
	logic [STAMP_BITS-1:0]        push_elapsed, pop_elapsed;
	logic [ENTRY_W-1:0]           push_data, pop_data;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q    <= uer_pkg::TPS_RESET;
			period_q <= uer_pkg::PERIOD_RESET;
			speed_q  <= uer_pkg::SPEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				uer_pkg::REG_TICKS_PER_SECOND: tps_q    <= cfg_wdata;
				uer_pkg::REG_TRIGGER_PERIOD:   period_q <= cfg_wdata[uer_pkg::PERIOD_W-1:0];
				uer_pkg::REG_SPEED_FACTOR:     speed_q  <= cfg_wdata[uer_pkg::SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input handshake: take items while the queue has room.
	assign event_stall = q_status.full;
	assign accept      = event_valid && !q_status.full;

	uer_front #(
		.STAMP_BITS (STAMP_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.item           (event_item),
		.trigger_period (period_q),
		.push_flags     (push_flags),
		.push_elapsed   (push_elapsed)
	);

	assign push_data = {push_flags, push_elapsed};
	assign {pop_flags, pop_elapsed} = pop_data;

	uer_queue #(
		.DATA_W (ENTRY_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	uer_back #(
		.STAMP_BITS (STAMP_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_status         (q_status),
		.q_flags          (pop_flags),
		.q_elapsed        (pop_elapsed),
		.pop              (pop),
		.ticks_per_second (tps_q),
		.speed_factor     (speed_q),
		.out_valid        (meas_valid),
		.out_stall        (meas_stall),
		.out_item         (meas_item)
	);

	// The queue can never report full and empty at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("item queue reports full and empty together");

	// The input side is never stalled while the queue is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_status.empty |-> !event_stall)
		else $error("input stalled with an empty queue");

	// A completed measurement always leaves the tracker expecting a rising edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		(meas_valid && meas_item.result_valid) |-> meas_item.expect_rising)
		else $error("measurement result without rising edge expected next");

	// The fractional part stays below one thousand.
	assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid |-> (meas_item.distance_thousandths <= uer_pkg::THOU_W'(999)))
		else $error("distance thousandths out of range");

endmodule

// ----- rtl/core/uer_front.sv -----
// Front part of the echo ranger: trigger tick counter and echo edge tracker.
// Classifies each accepted item for the back part. Depends on uer_pkg.

module uer_front #(
	parameter int STAMP_BITS = uer_pkg::STAMP_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  uer_pkg::event_t                   item,
	input  logic [uer_pkg::PERIOD_W-1:0]      trigger_period,
	output uer_pkg::entry_flags_t             push_flags,
	output logic [STAMP_BITS-1:0]             push_elapsed
);

	typedef enum logic [1:0] {
		PH_INIT = 2'd0,
		PH_RISE = 2'd1,
		PH_FALL = 2'd2
	} phase_t;

	phase_t                         phase_q, phase_next;
	logic [STAMP_BITS-1:0]          start_q, start_next, stamp;
	logic [uer_pkg::PERIOD_W-1:0]   tick_cnt_q, cnt_next, cnt_inc;
	logic                           trig_q, trig_next;
	logic                           measure;
	logic [STAMP_BITS-1:0]          elapsed;

	assign stamp   = STAMP_BITS'(item.capture_time);
	assign cnt_inc = tick_cnt_q + uer_pkg::PERIOD_W'(1);

	// Next state for the item now offered.
	always_comb begin
		cnt_next   = tick_cnt_q;
		trig_next  = trig_q;
		phase_next = phase_q;
		start_next = start_q;
		measure    = 1'b0;
		elapsed    = '0;
		if (item.command == uer_pkg::CMD_TICK) begin
			cnt_next = cnt_inc;
			if (cnt_inc == uer_pkg::PERIOD_W'(1)) begin
				trig_next = 1'b1;
			end
			if (cnt_inc == uer_pkg::PERIOD_W'(2)) begin
				trig_next = 1'b0;
			end
			if (cnt_inc == trigger_period) begin
				cnt_next = '0;
			end
		end else begin
			case (phase_q)
				PH_FALL: begin
					measure    = 1'b1;
					elapsed    = stamp - start_q;
					phase_next = PH_RISE;
				end
				default: begin
					// Initial, rising and the unused code all take a rising edge.
					start_next = stamp;
					phase_next = PH_FALL;
				end
			endcase
		end
	end

	// Classification handed to the queue.
	assign push_flags.trigger_out   = trig_next;
	assign push_flags.expect_rising = (phase_next != PH_FALL);
	assign push_flags.measure       = measure;
	assign push_elapsed             = elapsed;

	// State and counter update on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_INIT;
			start_q    <= '0;
			tick_cnt_q <= '0;
			trig_q     <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_next;
			start_q    <= start_next;
			tick_cnt_q <= cnt_next;
			trig_q     <= trig_next;
		end
	end

endmodule

// ----- rtl/core/uer_queue.sv -----
// Short item queue between the front and back parts of the echo ranger.
// Small register FIFO; depends on uer_pkg for its status struct.

module uer_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = uer_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [DATA_W-1:0]     push_data,
	input  logic                  pop,
	output logic [DATA_W-1:0]     pop_data,
	output uer_pkg::queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	// Storage is written only at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/uer_back.sv -----
// Back part of the echo ranger: pulse width division and distance math.
// Iterative pulse divider, reciprocal distance split and the result register.
// Depends on uer_pkg.

module uer_back #(
	parameter int STAMP_BITS = uer_pkg::STAMP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uer_pkg::queue_status_t        q_status,
	input  uer_pkg::entry_flags_t         q_flags,
	input  logic [STAMP_BITS-1:0]         q_elapsed,
	output logic                          pop,
	input  logic [uer_pkg::TPS_W-1:0]     ticks_per_second,
	input  logic [uer_pkg::SPEED_W-1:0]   speed_factor,
	output logic                          out_valid,
	input  logic                          out_stall,
	output uer_pkg::result_t              out_item
);

	localparam int DIVD_W = STAMP_BITS + uer_pkg::US_W;
	localparam int LIM_W  = uer_pkg::TPS_W + uer_pkg::PULSE_W;
	localparam int CMP_W  = (DIVD_W > LIM_W) ? DIVD_W : LIM_W;
	localparam int STEP_W = $clog2(uer_pkg::PULSE_W);
	localparam int PW     = uer_pkg::PROD_W;

	// 2000 = 16 * 125. The product shifted right by four is below 2^20, where
	// multiplying by ceil(2^27 / 125) and dropping 27 bits gives the exact quotient.
	localparam int              DQ_SHIFT  = 4;
	localparam int              DQ_W      = PW - DQ_SHIFT;
	localparam int              RCP_W     = 21;
	localparam int              RCP_SHIFT = 27;
	localparam int              RP_W      = DQ_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP_125  = 21'd1073742;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL1,
		B_SAT,
		B_DIV1,
		B_MUL2,
		B_DIV2,
		B_REM,
		B_OUT
	} back_state_t;

	back_state_t                  state_q;
	uer_pkg::entry_flags_t        flags_q;
	logic [STAMP_BITS-1:0]        elapsed_q;
	logic [CMP_W-1:0]             rem_q;
	logic [uer_pkg::PULSE_W-1:0]  quo_q, quo_next;
	logic [uer_pkg::PULSE_W-1:0]  last_pulse_q;
	logic [PW-1:0]                prod_q;
	logic [uer_pkg::WHOLE_W-1:0]  whole_q;
	logic [STEP_W-1:0]            step_q;
	uer_pkg::result_t             result_q;

	logic [DIVD_W-1:0]            mul_us;
	logic [PW-1:0]                mul_dist;
	logic [CMP_W-1:0]             sat_lim, div_shift;
	logic                         div_ge;
	logic [RP_W-1:0]              recip_prod;
	logic [PW-1:0]                whole_scaled, dist_rem;

	// Elapsed ticks scaled to microsecond units, one multiply.
	assign mul_us = {{(DIVD_W - STAMP_BITS){1'b0}}, elapsed_q}
		* {{STAMP_BITS{1'b0}}, uer_pkg::US_PER_S};

	// Distance product of speed and pulse width.
	assign mul_dist = {{(PW - uer_pkg::SPEED_W){1'b0}}, speed_factor}
		* {{(PW - uer_pkg::PULSE_W){1'b0}}, last_pulse_q};

	// Saturation limit: a quotient of 2^16 or more clips to the maximum.
	assign sat_lim = CMP_W'(ticks_per_second) << uer_pkg::PULSE_W;

	// Pulse division step, one quotient bit per cycle.
	assign div_shift = CMP_W'(ticks_per_second) << step_q;
	assign div_ge    = (rem_q >= div_shift);
	always_comb begin
		quo_next = quo_q;
		if (div_ge) begin
			quo_next[step_q] = 1'b1;
		end
	end

	// Whole centimeters by reciprocal multiplication, then the remainder.
	assign recip_prod = {{RCP_W{1'b0}}, prod_q[PW-1:DQ_SHIFT]} * {{DQ_W{1'b0}}, RCP_125};
	assign whole_scaled = {{(PW - uer_pkg::WHOLE_W){1'b0}}, whole_q}
		* PW'(uer_pkg::HALF_MM_DIV);
	assign dist_rem = prod_q - whole_scaled;

	assign pop       = (state_q == B_IDLE) && !q_status.empty;
	assign out_valid = (state_q == B_OUT);
	assign out_item  = result_q;

	// Sequencer, divider and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			last_pulse_q <= '0;
			step_q       <= '0;
			flags_q      <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!q_status.empty) begin
						flags_q   <= q_flags;
						elapsed_q <= q_elapsed;
						state_q   <= q_flags.measure ? B_MUL1 : B_MUL2;
					end
				end
				B_MUL1: begin
					rem_q   <= CMP_W'(mul_us);
					state_q <= B_SAT;
				end
				B_SAT: begin
					if (rem_q >= sat_lim) begin
						last_pulse_q <= uer_pkg::PULSE_MAX;
						state_q      <= B_MUL2;
					end else begin
						quo_q   <= '0;
						step_q  <= STEP_W'(uer_pkg::PULSE_W - 1);
						state_q <= B_DIV1;
					end
				end
				B_DIV1: begin
					quo_q <= quo_next;
					if (div_ge) begin
						rem_q <= rem_q - div_shift;
					end
					if (step_q == '0) begin
						last_pulse_q <= quo_next;
						state_q      <= B_MUL2;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				B_MUL2: begin
					prod_q  <= mul_dist;
					state_q <= B_DIV2;
				end
				B_DIV2: begin
					whole_q <= recip_prod[RCP_SHIFT +: uer_pkg::WHOLE_W];
					state_q <= B_REM;
				end
				B_REM: begin
					// Thousandths are half the remainder modulo 2000.
					result_q.trigger_out          <= flags_q.trigger_out;
					result_q.expect_rising        <= flags_q.expect_rising;
					result_q.result_valid         <= flags_q.measure;
					result_q.pulse_us             <= last_pulse_q;
					result_q.distance_whole       <= whole_q;
					result_q.distance_thousandths <= dist_rem[uer_pkg::THOU_W:1];
					state_q                       <= B_OUT;
				end
				B_OUT: begin
					if (!out_stall) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
